// ===== design/eqc_pkg.sv =====
// Shared types, constants and helpers for the stereo biquad cascade equalizer.
// Used by eqc_band_engine, eqc_scale and stereo_biquad_cascade_eq.
`default_nettype none

package eqc_pkg;

	localparam int BAND_COUNT     = 16;
	localparam int BAND_W         = 4;
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_FRAC_BITS = 24;
	localparam int COEF_W         = 28;
	localparam int HIST_W         = 32;
	localparam int HIST_FRAC      = 26;
	localparam int IN_SHIFT       = HIST_FRAC - (SAMPLE_BITS - 1);
	localparam int COEF_SELS      = 5;
	localparam int COEF_DEPTH     = BAND_COUNT * COEF_SELS;
	localparam int COEF_AW        = $clog2(COEF_DEPTH);
	localparam int HIST_DEPTH     = BAND_COUNT * 8;
	localparam int HIST_AW        = $clog2(HIST_DEPTH);
	localparam int PROD_W         = COEF_W + HIST_W;
	localparam int ACC_W          = 64;
	localparam int VOL_W          = 8;
	localparam int MAG_W          = HIST_FRAC + 1;
	localparam int QUOT_W         = SAMPLE_BITS;
	localparam int QBIT_W         = $clog2(QUOT_W);
	localparam int DIV_W          = MAG_W + VOL_W + 2;
	localparam int CFG_IDX_W      = 2;

	localparam logic [1:0] FUNC_FRAME = 2'd0;
	localparam logic [1:0] FUNC_COEF  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_EQ_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOL_STEP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VOL_MAX    = 2'd2;

	localparam logic [2:0] SEL_B0 = 3'd0;
	localparam logic [2:0] SEL_B1 = 3'd1;
	localparam logic [2:0] SEL_B2 = 3'd2;
	localparam logic [2:0] SEL_A1 = 3'd3;
	localparam logic [2:0] SEL_A2 = 3'd4;

	// Engine phases: reads issue in phases 0..4, history writes in 3, 4, 5 and 7.
	localparam logic [2:0] PH_FIRST_DATA = 3'd1;
	localparam logic [2:0] PH_ACC_FIRST  = 3'd2;
	localparam logic [2:0] PH_X1_SEEN    = 3'd2;
	localparam logic [2:0] PH_X2_WR      = 3'd3;
	localparam logic [2:0] PH_X1_WR      = 3'd4;
	localparam logic [2:0] PH_Y1_SEEN    = 3'd4;
	localparam logic [2:0] PH_Y2_WR      = 3'd5;
	localparam logic [2:0] PH_ACC_LAST   = 3'd6;
	localparam logic [2:0] PH_LAST       = 3'd7;

	localparam logic [1:0] SLOT_X1 = 2'd0;
	localparam logic [1:0] SLOT_X2 = 2'd1;
	localparam logic [1:0] SLOT_Y1 = 2'd2;
	localparam logic [1:0] SLOT_Y2 = 2'd3;

	localparam logic signed [COEF_W-1:0] COEF_ONE =
		{{(COEF_W-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_KICK,
		ST_RUN,
		ST_SC_KICK,
		ST_SC_RUN,
		ST_EMIT
	} eq_state_t;

	typedef enum logic [1:0] {
		SS_IDLE,
		SS_LOAD,
		SS_DIV,
		SS_DONE
	} scale_state_t;

	typedef struct packed {
		logic                     en;
		logic [BAND_W-1:0]        band;
		logic [2:0]               sel;
		logic signed [COEF_W-1:0] value;
	} coef_wr_t;

	typedef struct packed {
		logic                     start;
		logic [BAND_W-1:0]        band;
		logic                     ch;
		logic signed [HIST_W-1:0] x;
	} eng_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic signed [HIST_W-1:0] y;
	} eng_rsp_t;

	typedef struct packed {
		logic                     start;
		logic signed [HIST_W-1:0] y;
		logic [VOL_W-1:0]         step;
		logic [VOL_W-1:0]         den;
	} scl_req_t;

	function automatic logic signed [COEF_W-1:0] coef_ident(input logic [2:0] sel);
		return (sel == SEL_B0) ? COEF_ONE : '0;
	endfunction

endpackage

`default_nettype wire

// ===== design/eqc_band_engine.sv =====
// Runs one biquad band of one channel per request on a single shared multiply-accumulate unit.
// Holds the coefficient and history memories; depends on eqc_pkg.
`default_nettype none

module eqc_band_engine import eqc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire coef_wr_t          coef_wr,
	input  wire logic              hist_clear,
	input  wire logic [BAND_W-1:0] query_band,
	output logic                   query_bypass,
	input  wire eng_req_t          req,
	output eng_rsp_t               rsp
);

	logic                      busy_q;
	logic [2:0]                ph_q;
	logic [BAND_W-1:0]         band_q;
	logic                      ch_q;
	logic signed [HIST_W-1:0]  x_q;
	logic signed [HIST_W-1:0]  x1_q;
	logic signed [HIST_W-1:0]  y1_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      neg_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [COEF_W-1:0]  coef_mem [COEF_DEPTH];
	logic [COEF_DEPTH-1:0]     coef_id_q;
	logic signed [COEF_W-1:0]  coef_rd_q;
	logic                      coef_hit_q;

	logic signed [HIST_W-1:0]  hist_mem [HIST_DEPTH];
	logic [HIST_DEPTH-1:0]     hist_live_q;
	logic signed [HIST_W-1:0]  hist_rd_q;
	logic                      hist_rd_live_q;

	logic                      coef_we;
	logic [COEF_AW-1:0]        coef_waddr;
	logic [COEF_AW-1:0]        coef_raddr;
	logic [COEF_AW-1:0]        query_base;
	logic [2:0]                rd_k;
	logic [1:0]                rd_slot;
	logic [HIST_AW-1:0]        hist_raddr;
	logic [2:0]                dk;
	logic signed [COEF_W-1:0]  coef_op;
	logic signed [HIST_W-1:0]  hist_op;
	logic signed [HIST_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ACC_W-1:0]   acc_base;
	logic signed [ACC_W-1:0]   acc_next;
	logic signed [ACC_W-1:0]   acc_sh;
	logic                      acc_ovf;
	logic signed [HIST_W-1:0]  y;
	logic                      hist_we;
	logic [1:0]                wr_slot;
	logic signed [HIST_W-1:0]  hist_wdata;
	logic [HIST_AW-1:0]        hist_waddr;

	assign coef_we = coef_wr.en && (coef_wr.sel <= SEL_A2)
		&& (int'(coef_wr.band) < BAND_COUNT);
	assign coef_waddr = COEF_AW'(coef_wr.band) * COEF_AW'(COEF_SELS) + COEF_AW'(coef_wr.sel);
	assign query_base = COEF_AW'(query_band) * COEF_AW'(COEF_SELS);
	assign query_bypass = &coef_id_q[query_base +: COEF_SELS];

	always_comb begin
		rd_k = (ph_q > SEL_A2) ? SEL_A2 : ph_q;
		if (ph_q == 3'd0) begin
			rd_slot = SLOT_X1;
		end else if (ph_q > SEL_A2) begin
			rd_slot = SLOT_Y2;
		end else begin
			rd_slot = 2'(ph_q - 3'd1);
		end
	end

	assign coef_raddr = COEF_AW'(band_q) * COEF_AW'(COEF_SELS) + COEF_AW'(rd_k);
	assign hist_raddr = {band_q, ch_q, rd_slot};

	assign dk      = ph_q - 3'd1;
	assign coef_op = coef_hit_q ? coef_ident(dk) : coef_rd_q;
	assign hist_op = hist_rd_live_q ? hist_rd_q : '0;
	assign mul_b   = (ph_q == PH_FIRST_DATA) ? x_q : hist_op;
	assign prod    = PROD_W'(coef_op) * PROD_W'(mul_b);

	assign acc_base = (ph_q == PH_ACC_FIRST) ? '0 : acc_q;
	assign acc_next = neg_q ? acc_base - ACC_W'(prod_q) : acc_base + ACC_W'(prod_q);

	always_comb begin
		acc_sh  = (acc_q + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
		acc_ovf = !((&acc_sh[ACC_W-1:HIST_W-1]) || !(|acc_sh[ACC_W-1:HIST_W-1]));
		if (acc_ovf) begin
			y = acc_sh[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
		end else begin
			y = acc_sh[HIST_W-1:0];
		end
	end

	always_comb begin
		hist_we    = 1'b0;
		wr_slot    = SLOT_X1;
		hist_wdata = x_q;
		if (busy_q) begin
			case (ph_q)
				PH_X2_WR: begin
					hist_we    = 1'b1;
					wr_slot    = SLOT_X2;
					hist_wdata = x1_q;
				end
				PH_X1_WR: begin
					hist_we    = 1'b1;
					wr_slot    = SLOT_X1;
					hist_wdata = x_q;
				end
				PH_Y2_WR: begin
					hist_we    = 1'b1;
					wr_slot    = SLOT_Y2;
					hist_wdata = y1_q;
				end
				PH_LAST: begin
					hist_we    = 1'b1;
					wr_slot    = SLOT_Y1;
					hist_wdata = y;
				end
				default: begin
					hist_we = 1'b0;
				end
			endcase
		end
	end

	assign hist_waddr = {band_q, ch_q, wr_slot};

	assign rsp.busy = busy_q;
	assign rsp.done = busy_q && (ph_q == PH_LAST);
	assign rsp.y    = y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			ph_q   <= '0;
		end else if (busy_q) begin
			if (ph_q == PH_LAST) begin
				busy_q <= 1'b0;
			end
			ph_q <= ph_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			band_q <= req.band;
			ch_q   <= req.ch;
			x_q    <= req.x;
		end
		prod_q <= prod;
		neg_q  <= (dk >= SEL_A1);
		if (busy_q && ph_q >= PH_ACC_FIRST && ph_q <= PH_ACC_LAST) begin
			acc_q <= acc_next;
		end
		if (busy_q && ph_q == PH_X1_SEEN) begin
			x1_q <= hist_op;
		end
		if (busy_q && ph_q == PH_Y1_SEEN) begin
			y1_q <= hist_op;
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= coef_wr.value;
		end
		coef_rd_q <= coef_mem[coef_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_id_q  <= '1;
			coef_hit_q <= 1'b0;
		end else begin
			if (coef_we) begin
				coef_id_q[coef_waddr] <= (coef_wr.value == coef_ident(coef_wr.sel));
			end
			coef_hit_q <= coef_id_q[coef_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		hist_rd_q <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_live_q    <= '0;
			hist_rd_live_q <= 1'b0;
		end else begin
			if (hist_clear) begin
				hist_live_q <= '0;
			end else if (hist_we) begin
				hist_live_q[hist_waddr] <= 1'b1;
			end
			hist_rd_live_q <= hist_live_q[hist_raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/eqc_scale.sv =====
// Output stage: clip to +-1.0, volume scaling and rounding by a bit-serial divider.
// Depends on eqc_pkg.
`default_nettype none

module eqc_scale import eqc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire scl_req_t                 req,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] q
);

	localparam logic signed [HIST_W-1:0] ONE_POS = HIST_W'(1) <<< HIST_FRAC;
	localparam logic signed [HIST_W-1:0] ONE_NEG = -(HIST_W'(1) <<< HIST_FRAC);

	scale_state_t          state_q;
	scale_state_t          state_d;
	logic [MAG_W-1:0]      mag_q;
	logic                  neg_q;
	logic [VOL_W-1:0]      step_q;
	logic [VOL_W-1:0]      den_q;
	logic [DIV_W-1:0]      rem_q;
	logic [DIV_W-1:0]      dsh_q;
	logic [QUOT_W-1:0]     quot_q;
	logic [QBIT_W-1:0]     bit_q;

	logic signed [HIST_W-1:0] y_clip;
	logic [HIST_W-1:0]        y_abs;
	logic                     unity;
	logic                     ge;

	always_comb begin
		if (req.y > ONE_POS) begin
			y_clip = ONE_POS;
		end else if (req.y < ONE_NEG) begin
			y_clip = ONE_NEG;
		end else begin
			y_clip = req.y;
		end
		y_abs = y_clip[HIST_W-1] ? HIST_W'(-y_clip) : HIST_W'(y_clip);
		unity = (req.den == '0) || (req.step >= req.den);
	end

	assign ge = (rem_q >= dsh_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SS_IDLE: if (req.start) state_d = SS_LOAD;
			SS_LOAD: state_d = SS_DIV;
			SS_DIV:  if (bit_q == '0) state_d = SS_DONE;
			SS_DONE: state_d = SS_IDLE;
			default: state_d = SS_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == SS_DONE);
		if (neg_q) begin
			q = QUOT_W'(0) - quot_q;
		end else if (quot_q[QUOT_W-1]) begin
			q = {1'b0, {(QUOT_W-1){1'b1}}};
		end else begin
			q = quot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SS_IDLE: begin
				mag_q  <= y_abs[MAG_W-1:0];
				neg_q  <= y_clip[HIST_W-1];
				step_q <= unity ? VOL_W'(1) : req.step;
				den_q  <= unity ? VOL_W'(1) : req.den;
			end
			SS_LOAD: begin
				rem_q  <= ((DIV_W'(mag_q) * DIV_W'(step_q)) << 1) + (DIV_W'(den_q) << IN_SHIFT);
				dsh_q  <= DIV_W'(den_q) << (IN_SHIFT + QUOT_W);
				quot_q <= '0;
				bit_q  <= QBIT_W'(QUOT_W - 1);
			end
			SS_DIV: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q  <= dsh_q >> 1;
				quot_q <= {quot_q[QUOT_W-2:0], ge};
				bit_q  <= bit_q - QBIT_W'(1);
			end
			default: begin
				bit_q <= bit_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/stereo_biquad_cascade_eq.sv =====
// Top level of the stereo biquad cascade equalizer: configuration, sequencer, output register.
// Depends on eqc_pkg, eqc_band_engine and eqc_scale.
//
// Items arrive on in_valid/in_ready. func selects a frame, a coefficient write or a
// history clear; only a frame gives a result, on out_valid/out_ready. Configuration
// registers (enable, volume step, volume maximum) are written through cfg_we.
// A frame runs each channel through every band whose coefficients are not the
// identity, on one shared multiply-accumulate unit, when enable is set; with enable
// clear it skips the bands. For each band the sequencer checks it, then starts and
// runs the engine for the left and then the right channel; an identity band is only
// checked. The two output samples are then scaled by a 16-step serial divider.
// Coefficient writes and history clears are applied on acceptance. in_ready is high
// only while the sequencer is idle. A finished frame waits in the output register
// while the next item is accepted; if the receiver still stalls when another frame
// finishes, that frame holds until the register frees. Reset loads identity
// coefficients, clears the history, empties the output register and sets enable 1,
// step 0, maximum 21.
`default_nettype none

module stereo_biquad_cascade_eq import eqc_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [VOL_W-1:0]           cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 func,
	input  wire logic signed [SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [SAMPLE_BITS-1:0] right_in,
	input  wire logic [BAND_W-1:0]          band,
	input  wire logic [2:0]                 coef_sel,
	input  wire logic signed [COEF_W-1:0]   coef_value,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_BITS-1:0]   left_out,
	output logic signed [SAMPLE_BITS-1:0]   right_out
);

	eq_state_t                     state_q;
	eq_state_t                     state_d;
	logic [BAND_W-1:0]             band_q;
	logic                          ch_q;
	logic                          eq_enable_q;
	logic [VOL_W-1:0]              volume_step_q;
	logic [VOL_W-1:0]              volume_max_q;
	logic                          out_valid_q;
	logic signed [HIST_W-1:0]      yl_q;
	logic signed [HIST_W-1:0]      yr_q;
	logic signed [SAMPLE_BITS-1:0] ql_q;
	logic signed [SAMPLE_BITS-1:0] qr_q;
	logic signed [SAMPLE_BITS-1:0] left_out_q;
	logic signed [SAMPLE_BITS-1:0] right_out_q;

	logic                          accept;
	logic                          band_last;
	logic                          bypass;
	logic                          load_out;
	coef_wr_t                      coef_wr;
	logic                          hist_clear;
	eng_req_t                      eng_req;
	eng_rsp_t                      eng_rsp;
	scl_req_t                      scl_req;
	logic                          scl_done;
	logic signed [SAMPLE_BITS-1:0] scl_q;

	assign accept    = in_valid && in_ready;
	assign band_last = (band_q == BAND_W'(BAND_COUNT - 1));

	assign coef_wr.en    = accept && (func == FUNC_COEF);
	assign coef_wr.band  = band;
	assign coef_wr.sel   = coef_sel;
	assign coef_wr.value = coef_value;
	assign hist_clear    = accept && (func == FUNC_CLEAR);

	assign eng_req.start = (state_q == ST_KICK);
	assign eng_req.band  = band_q;
	assign eng_req.ch    = ch_q;
	assign eng_req.x     = ch_q ? yr_q : yl_q;

	assign scl_req.start = (state_q == ST_SC_KICK);
	assign scl_req.y     = ch_q ? yr_q : yl_q;
	assign scl_req.step  = volume_step_q;
	assign scl_req.den   = volume_max_q;

	eqc_band_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.coef_wr      (coef_wr),
		.hist_clear   (hist_clear),
		.query_band   (band_q),
		.query_bypass (bypass),
		.req          (eng_req),
		.rsp          (eng_rsp)
	);

	eqc_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scl_req),
		.done   (scl_done),
		.q      (scl_q)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_FRAME) begin
					state_d = eq_enable_q ? ST_SCAN : ST_SC_KICK;
				end
			end
			ST_SCAN: begin
				if (!bypass) begin
					state_d = ST_KICK;
				end else if (band_last) begin
					state_d = ST_SC_KICK;
				end
			end
			ST_KICK: state_d = ST_RUN;
			ST_RUN: begin
				if (eng_rsp.done) begin
					if (!ch_q) begin
						state_d = ST_KICK;
					end else if (band_last) begin
						state_d = ST_SC_KICK;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SC_KICK: state_d = ST_SC_RUN;
			ST_SC_RUN: begin
				if (scl_done) begin
					state_d = ch_q ? ST_EMIT : ST_SC_KICK;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		load_out = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			band_q        <= '0;
			ch_q          <= 1'b0;
			eq_enable_q   <= 1'b1;
			volume_step_q <= 8'd0;
			volume_max_q  <= 8'd21;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_EQ_ENABLE: eq_enable_q   <= cfg_data[0];
					CFG_VOL_STEP:  volume_step_q <= cfg_data;
					CFG_VOL_MAX:   volume_max_q  <= cfg_data;
					default:       eq_enable_q   <= eq_enable_q;
				endcase
			end
			if (accept) begin
				band_q <= '0;
				ch_q   <= 1'b0;
			end
			if (state_q == ST_SCAN && bypass && !band_last) begin
				band_q <= band_q + BAND_W'(1);
			end
			if (state_q == ST_RUN && eng_rsp.done) begin
				ch_q <= !ch_q;
				if (ch_q && !band_last) begin
					band_q <= band_q + BAND_W'(1);
				end
			end
			if (state_q == ST_SC_RUN && scl_done) begin
				ch_q <= !ch_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			yl_q <= {{(HIST_W-SAMPLE_BITS){left_in[SAMPLE_BITS-1]}}, left_in} <<< IN_SHIFT;
			yr_q <= {{(HIST_W-SAMPLE_BITS){right_in[SAMPLE_BITS-1]}}, right_in} <<< IN_SHIFT;
		end
		if (state_q == ST_RUN && eng_rsp.done) begin
			if (ch_q) begin
				yr_q <= eng_rsp.y;
			end else begin
				yl_q <= eng_rsp.y;
			end
		end
		if (state_q == ST_SC_RUN && scl_done) begin
			if (ch_q) begin
				qr_q <= scl_q;
			end else begin
				ql_q <= scl_q;
			end
		end
		if (load_out) begin
			left_out_q  <= ql_q;
			right_out_q <= qr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// The band engine only finishes while the sequencer waits for it.
	a_eng_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		eng_rsp.done |-> (state_q == ST_RUN))
		else $error("band engine finished outside its run state");

	// The scaler only finishes while the sequencer waits for it.
	a_scl_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		scl_done |-> (state_q == ST_SC_RUN))
		else $error("scaler finished outside its run state");

	// No new item is taken while the band engine still works.
	a_ready_engine_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !eng_rsp.busy)
		else $error("input ready while the band engine is busy");

	// A finished frame that finds the output register free shows up there next cycle.
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid)
		else $error("finished frame did not reach the output register");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for stereo_biquad_cascade_eq: a directed table, then random phases.
// Depends on eqc_pkg and the design; expected samples come from an in-bench equalizer model or from typed table rows.

module tb_top;
	import eqc_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [2:0] SEL_BAD_LO = 3'd5;
	localparam logic [2:0] SEL_BAD_HI = 3'd7;
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;
	localparam logic signed [COEF_W-1:0] C_MAX = 28'sh7FFFFFF;
	localparam logic signed [COEF_W-1:0] C_MIN = 28'sh8000000;
	localparam logic signed [COEF_W-1:0] C_ZERO = '0;
	localparam logic [2:0] SEL_ORDER [COEF_SELS] = '{SEL_B0, SEL_B1, SEL_B2, SEL_A1, SEL_A2};
	localparam int COEF_UNIT = 1 << COEF_FRAC_BITS;
	localparam int A2_LIM = (COEF_UNIT / 10) * 9;
	localparam int DIR_ROWS = 25;
	localparam int DIR_RESET_ROWS = 2;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 120;
	localparam int HOLD_CYCLES = 1500;
	localparam int DRAIN_TAIL = 400;
	localparam int QUIET_LIMIT = 20000;
	localparam longint HIST_MAX = (64'sd1 <<< (HIST_W - 1)) - 1;
	localparam longint HIST_MIN = -(64'sd1 <<< (HIST_W - 1));

	typedef struct packed {
		logic [1:0]                    f;
		logic signed [SAMPLE_BITS-1:0] l;
		logic signed [SAMPLE_BITS-1:0] r;
		logic [BAND_W-1:0]             b;
		logic [2:0]                    s;
		logic signed [COEF_W-1:0]      v;
	} eq_item_t;

	typedef struct packed {
		eq_item_t                      it;
		logic                          typed;
		logic signed [SAMPLE_BITS-1:0] tl;
		logic signed [SAMPLE_BITS-1:0] tr;
	} dir_row_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] l;
		logic signed [SAMPLE_BITS-1:0] r;
	} frame_exp_t;

	typedef struct {
		int         send_idle;
		int         recv_stall;
		logic       en;
		logic [7:0] step;
		logic [7:0] vmax;
	} phase_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VOL_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = FUNC_FRAME;
	logic signed [SAMPLE_BITS-1:0] left_in = '0;
	logic signed [SAMPLE_BITS-1:0] right_in = '0;
	logic [BAND_W-1:0] band = '0;
	logic [2:0] coef_sel = SEL_B0;
	logic signed [COEF_W-1:0] coef_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	stereo_biquad_cascade_eq dut (.*);

	logic                     mdl_enable;
	logic [VOL_W-1:0]         mdl_step;
	logic [VOL_W-1:0]         mdl_max;
	logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
	logic signed [HIST_W-1:0] hist_mem [HIST_DEPTH];

	frame_exp_t frame_exp_q [$];
	dir_row_t   dir_tab [DIR_ROWS];
	phase_t     phase_tab [PHASES];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_go = 1'b0;
	int mism_count = 0;
	int n_frames = 0;
	int n_coef = 0;
	int n_clear = 0;
	int n_ignored = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void model_reset();
		mdl_enable = 1'b1;
		mdl_step = 8'd0;
		mdl_max = 8'd21;
		for (int i = 0; i < COEF_DEPTH; i++) begin
			coef_mem[i] = (i % COEF_SELS == SEL_B0) ? COEF_ONE : C_ZERO;
		end
		for (int i = 0; i < HIST_DEPTH; i++) begin
			hist_mem[i] = '0;
		end
	endfunction

	function automatic longint run_section(input int b, input int ch, input longint x);
		int cb;
		int hb;
		longint acc;
		longint y;
		cb = b * COEF_SELS;
		hb = (b * 2 + ch) * 4;
		acc = longint'(coef_mem[cb + SEL_B0]) * x
			+ longint'(coef_mem[cb + SEL_B1]) * longint'(hist_mem[hb + SLOT_X1])
			+ longint'(coef_mem[cb + SEL_B2]) * longint'(hist_mem[hb + SLOT_X2])
			- longint'(coef_mem[cb + SEL_A1]) * longint'(hist_mem[hb + SLOT_Y1])
			- longint'(coef_mem[cb + SEL_A2]) * longint'(hist_mem[hb + SLOT_Y2]);
		y = (acc + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
		if (y > HIST_MAX) y = HIST_MAX;
		if (y < HIST_MIN) y = HIST_MIN;
		hist_mem[hb + SLOT_X2] = hist_mem[hb + SLOT_X1];
		hist_mem[hb + SLOT_X1] = x[HIST_W-1:0];
		hist_mem[hb + SLOT_Y2] = hist_mem[hb + SLOT_Y1];
		hist_mem[hb + SLOT_Y1] = y[HIST_W-1:0];
		return y;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] scale_out(input longint y_in);
		longint one;
		longint top;
		longint y;
		longint stp;
		longint den;
		longint n;
		longint d;
		longint mag;
		longint q;
		one = 64'sd1 <<< HIST_FRAC;
		top = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
		y = y_in;
		if (y > one) y = one;
		if (y < -one) y = -one;
		stp = longint'(mdl_step);
		den = longint'(mdl_max);
		if (den == 0 || stp >= den) begin
			stp = 1;
			den = 1;
		end
		n = y * stp;
		d = den <<< IN_SHIFT;
		mag = (n < 0) ? -n : n;
		q = (mag * 2 + d) / (2 * d);
		if (n < 0) q = -q;
		if (q > top) q = top;
		return q[SAMPLE_BITS-1:0];
	endfunction

	function automatic void eq_predict(input eq_item_t it, output logic hit,
			output logic signed [SAMPLE_BITS-1:0] pl, output logic signed [SAMPLE_BITS-1:0] pr);
		longint yl;
		longint yr;
		int cb;
		hit = 1'b0;
		pl = '0;
		pr = '0;
		case (it.f)
			FUNC_COEF: begin
				if (it.b < BAND_COUNT && it.s < COEF_SELS) coef_mem[it.b * COEF_SELS + it.s] = it.v;
			end
			FUNC_CLEAR: begin
				for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = '0;
			end
			FUNC_FRAME: begin
				yl = longint'(it.l) <<< IN_SHIFT;
				yr = longint'(it.r) <<< IN_SHIFT;
				if (mdl_enable) begin
					for (int b = 0; b < BAND_COUNT; b++) begin
						cb = b * COEF_SELS;
						if (coef_mem[cb + SEL_B0] == COEF_ONE && coef_mem[cb + SEL_B1] == 0 &&
								coef_mem[cb + SEL_B2] == 0 && coef_mem[cb + SEL_A1] == 0 &&
								coef_mem[cb + SEL_A2] == 0)
							continue;
						yl = run_section(b, 0, yl);
						yr = run_section(b, 1, yr);
					end
				end
				hit = 1'b1;
				pl = scale_out(yl);
				pr = scale_out(yr);
			end
			default: ;
		endcase
	endfunction

	function automatic eq_item_t rand_item(input logic [1:0] f);
		eq_item_t it;
		it.f = f;
		it.l = SAMPLE_BITS'($urandom);
		it.r = SAMPLE_BITS'($urandom);
		it.b = BAND_W'($urandom);
		it.s = 3'($urandom);
		it.v = COEF_W'($urandom);
		return it;
	endfunction

	task automatic send_item(input eq_item_t it, input logic typed,
			input logic signed [SAMPLE_BITS-1:0] tl, input logic signed [SAMPLE_BITS-1:0] tr);
		logic hit;
		logic signed [SAMPLE_BITS-1:0] pl;
		logic signed [SAMPLE_BITS-1:0] pr;
		frame_exp_t e;
		while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= it.f;
		left_in <= it.l;
		right_in <= it.r;
		band <= it.b;
		coef_sel <= it.s;
		coef_value <= it.v;
		do @(posedge clk); while (!in_ready);
		eq_predict(it, hit, pl, pr);
		if (hit) begin
			e.l = typed ? tl : pl;
			e.r = typed ? tr : pr;
			frame_exp_q.push_back(e);
		end
		case (it.f)
			FUNC_FRAME: n_frames++;
			FUNC_COEF:  n_coef++;
			FUNC_CLEAR: n_clear++;
			default:    n_ignored++;
		endcase
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (frame_exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VOL_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_EQ_ENABLE: mdl_enable = data[0];
			CFG_VOL_STEP:  mdl_step = data;
			CFG_VOL_MAX:   mdl_max = data;
			default: ;
		endcase
	endtask

	task automatic run_phase(input int ph);
		int n;
		int pick;
		int stop;
		int a1;
		int a2;
		int lim;
		bit paused;
		eq_item_t it;
		logic signed [COEF_W-1:0] cv [COEF_SELS];
		n = 0;
		paused = 1'b0;
		while (n < PHASE_ITEMS) begin
			if (ph == 1 && !paused && n >= PHASE_ITEMS / 2) begin
				wait_drain();
				paused = 1'b1;
			end
			pick = $urandom_range(1, 100);
			if (pick <= 55) begin
				it = rand_item(FUNC_FRAME);
				if ($urandom_range(0, 7) == 0) begin
					it.l = $urandom_range(0, 1) ? S_MAX : S_MIN;
					it.r = $urandom_range(0, 1) ? S_MAX : S_MIN;
				end
				send_item(it, 1'b0, '0, '0);
				n++;
			end else if (pick <= 77) begin
				// A stable section: |a2| < 0.9 and |a1| at most 0.9 * (1 + a2).
				a2 = int'($urandom_range(0, 2 * A2_LIM)) - A2_LIM;
				lim = ((COEF_UNIT + a2) / 10) * 9;
				a1 = int'($urandom_range(0, 2 * lim)) - lim;
				for (int k = 0; k < 3; k++) begin
					cv[k] = COEF_W'(int'($urandom_range(0, 2 * COEF_UNIT)) - COEF_UNIT);
				end
				cv[3] = COEF_W'(a1);
				cv[4] = COEF_W'(a2);
				if (pick > 70) begin
					cv[0] = COEF_ONE;
					for (int k = 1; k < COEF_SELS; k++) cv[k] = C_ZERO;
				end
				stop = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : COEF_SELS;
				it = rand_item(FUNC_COEF);
				it.b = BAND_W'($urandom_range(0, BAND_COUNT - 1));
				for (int k = 0; k < stop; k++) begin
					it.s = SEL_ORDER[k];
					it.v = cv[k];
					it.l = SAMPLE_BITS'($urandom);
					it.r = SAMPLE_BITS'($urandom);
					send_item(it, 1'b0, '0, '0);
					n++;
				end
			end else if (pick <= 85) begin
				send_item(rand_item(FUNC_COEF), 1'b0, '0, '0);
				n++;
			end else if (pick <= 90) begin
				send_item(rand_item(FUNC_CLEAR), 1'b0, '0, '0);
				n++;
			end else begin
				send_item(rand_item(FUNC_NONE), 1'b0, '0, '0);
			end
		end
	endtask

	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
			end
		end
	end

	initial begin
		frame_exp_t e;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (frame_exp_q.size() == 0) begin
					if (mism_count < 10)
						$display("unexpected output item: left %0d right %0d", left_out, right_out);
					mism_count++;
				end else begin
					e = frame_exp_q.pop_front();
					if (left_out !== e.l || right_out !== e.r) begin
						if (mism_count < 10)
							$display("mismatch: left exp %0d got %0d, right exp %0d got %0d",
								e.l, left_out, e.r, right_out);
						mism_count++;
					end
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	initial begin
		dir_tab = '{
			'{'{FUNC_FRAME, S_MAX, S_MIN, 4'd0, SEL_B0, C_ZERO}, 1'b1, 16'sd0, 16'sd0},
			'{'{FUNC_FRAME, S_MIN, S_MAX, 4'd0, SEL_B0, C_ZERO}, 1'b1, 16'sd0, 16'sd0},
			'{'{FUNC_FRAME, S_MAX, S_MIN, 4'd0, SEL_B0, C_ZERO}, 1'b1, S_MAX, S_MIN},
			'{'{FUNC_FRAME, 16'sd0, 16'sd0, 4'd0, SEL_B0, C_ZERO}, 1'b1, 16'sd0, 16'sd0},
			'{'{FUNC_FRAME, 16'sd1, -16'sd1, 4'd0, SEL_B0, C_ZERO}, 1'b1, 16'sd1, -16'sd1},
			'{'{FUNC_NONE, 16'sd12345, -16'sd4321, 4'd9, SEL_B2, 28'sh5A5A5A5}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_FRAME, S_MIN, S_MAX, 4'd0, SEL_B0, C_ZERO}, 1'b1, S_MIN, S_MAX},
			'{'{FUNC_COEF, 16'sd0, 16'sd0, 4'd0, SEL_BAD_LO, C_ZERO}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_COEF, 16'sd0, 16'sd0, 4'd0, SEL_BAD_HI, C_MAX}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_FRAME, 16'sd12345, -16'sd12345, 4'd0, SEL_B0, C_ZERO}, 1'b1,
				16'sd12345, -16'sd12345},
			'{'{FUNC_COEF, 16'sd0, 16'sd0, 4'd0, SEL_B0, C_MAX}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_FRAME, S_MAX, S_MIN, 4'd0, SEL_B0, C_ZERO}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_COEF, 16'sd0, 16'sd0, 4'd15, SEL_A1, C_MIN}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_COEF, 16'sd0, 16'sd0, 4'd15, SEL_B1, COEF_ONE}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_FRAME, 16'sd1000, -16'sd1000, 4'd0, SEL_B0, C_ZERO}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_FRAME, S_MIN, S_MAX, 4'd0, SEL_B0, C_ZERO}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_CLEAR, 16'sd0, 16'sd0, 4'd0, SEL_B0, C_ZERO}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_FRAME, 16'sd0, 16'sd0, 4'd0, SEL_B0, C_ZERO}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_COEF, 16'sd0, 16'sd0, 4'd0, SEL_B0, COEF_ONE}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_COEF, 16'sd0, 16'sd0, 4'd15, SEL_A1, C_ZERO}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_COEF, 16'sd0, 16'sd0, 4'd15, SEL_B1, C_ZERO}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_FRAME, S_MAX, S_MIN, 4'd0, SEL_B0, C_ZERO}, 1'b1, S_MAX, S_MIN},
			'{'{FUNC_COEF, 16'sd0, 16'sd0, 4'd7, SEL_A2, 28'sh0400000}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_FRAME, -16'sd20000, 16'sd20000, 4'd0, SEL_B0, C_ZERO}, 1'b0, 16'sd0, 16'sd0},
			'{'{FUNC_FRAME, 16'sd20000, -16'sd20000, 4'd0, SEL_B0, C_ZERO}, 1'b0, 16'sd0, 16'sd0}
		};
		phase_tab[0] = '{0, 0, 1'b1, 8'd255, 8'd21};
		phase_tab[1] = '{73, 0, 1'b1, 8'd7, 8'd21};
		phase_tab[2] = '{0, 73, 1'b1, 8'd0, 8'd0};
		phase_tab[3] = '{34, 34, 1'b0, 8'd255, 8'd255};
		phase_tab[4] = '{0, 0, 1'b1, 8'd1, 8'd255};
		phase_tab[5] = '{73, 0, 1'b1, 8'd0, 8'd255};
		phase_tab[6] = '{0, 73, 1'b0, 8'd100, 8'd200};
		phase_tab[7] = '{34, 34, 1'b1, 8'd21, 8'd21};

		model_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == DIR_RESET_ROWS) begin
				wait_drain();
				write_reg(CFG_VOL_STEP, 8'd255);
			end
			send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].tl, dir_tab[i].tr);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drain();
			send_idle_pct = 0;
			recv_stall_pct = 0;
			write_reg(CFG_EQ_ENABLE, {7'($urandom_range(0, 127)), phase_tab[ph].en});
			write_reg(CFG_VOL_STEP, phase_tab[ph].step);
			write_reg(CFG_VOL_MAX, phase_tab[ph].vmax);
			if (ph == 3) write_reg(CFG_UNUSED, 8'($urandom));
			send_idle_pct = phase_tab[ph].send_idle;
			recv_stall_pct = phase_tab[ph].recv_stall;
			if (ph == 0) hold_go = 1'b1;
			run_phase(ph);
		end

		wait_drain();
		$display("Sent %0d frames, %0d coefficient writes, %0d history clears, %0d ignored items",
			n_frames, n_coef, n_clear, n_ignored);
		$display("over %0d register settings; %0d output mismatches", PHASES + 2, mism_count);
		if (mism_count == 0 && frame_exp_q.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
